// ----- sv/hea_pkg.sv -----
package hea_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_PWM_ZERO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_FULL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_TMO    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_PER_C = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 3'd6;

  localparam logic [1:0] REQ_EDGE   = 2'd0;
  localparam logic [1:0] REQ_LIMIT  = 2'd1;
  localparam logic [1:0] REQ_UPDATE = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam logic [15:0] RST_PWM_ZERO  = 16'd500;
  localparam logic [15:0] RST_PWM_FULL  = 16'd2500;
  localparam logic [15:0] RST_PULSE_MIN = 16'd500;
  localparam logic [15:0] RST_PULSE_MAX = 16'd2500;
  localparam logic [31:0] RST_PWM_TMO   = 32'd100000;
  localparam logic [23:0] RST_TPC       = 24'd4096;
  localparam logic [15:0] RST_ALPHA     = 16'd6554;

  localparam logic [31:0] LIMIT_HIGH_ADD = 32'h0000_7FFF;
  localparam logic [31:0] LIMIT_LOW_ADD  = 32'hFFFF_8000;

  localparam logic [24:0] ONE_TURN_ANG = 25'h100_0000;
  localparam logic signed [49:0] HALF_TURN = 50'sd8388608;
  localparam logic signed [49:0] ONE_TURN  = 50'sd16777216;
  localparam logic [63:0] VEL_NUM     = 64'd15625;
  localparam logic [63:0] VEL_Q_CAP   = 64'h0000_0000_8000_0000;
  localparam logic [16:0] ALPHA_ONE   = 17'h1_0000;
  localparam logic [6:0]  ANG_STEPS   = 7'd24;
  localparam logic [6:0]  VEL_STEPS   = 7'd64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP,
    ST_ADIV,
    ST_COMB,
    ST_DIFF,
    ST_VMUL,
    ST_VDIV,
    ST_VSAT,
    ST_FMUL1,
    ST_FMUL2,
    ST_FSCALE,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic accept;
    logic map;
    logic div_step;
    logic comb;
    logic diff;
    logic vmul;
    logic vsat;
    logic fmul1;
    logic fmul2;
    logic fscale;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic tick;
    logic updated;
    logic need_div;
    logic div_done;
    logic vel_en;
    logic out_busy;
  } sts_t;

  function automatic logic [31:0] inc_sat(input logic [31:0] v);
    inc_sat = (&v) ? v : v + 32'd1;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [56:0] v);
    if (!v[56] && (|v[55:47])) begin
      sat48 = {1'b0, {47{1'b1}}};
    end else if (v[56] && !(&v[55:47])) begin
      sat48 = {1'b1, {47{1'b0}}};
    end else begin
      sat48 = v[47:0];
    end
  endfunction

endpackage

// ----- sv/hea_if.sv -----
interface hea_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [31:0]        time_us;
  logic               pin_level;
  logic               limit_high;
  logic               limit_low;
  logic signed [15:0] count_now;
  logic               count_ok;

  modport src (output valid, req_type, time_us, pin_level, limit_high, limit_low,
               count_now, count_ok, input ready);
  modport snk (input valid, req_type, time_us, pin_level, limit_high, limit_low,
               count_now, count_ok, output ready);
endinterface

interface hea_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] angle;
  logic signed [31:0] velocity;
  logic               pwm_ok;
  logic               data_valid;
  logic [31:0]        error_total;

  modport src (output valid, angle, velocity, pwm_ok, data_valid, error_total,
               input ready);
  modport snk (input valid, angle, velocity, pwm_ok, data_valid, error_total,
               output ready);
endinterface

interface hea_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hea_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                    data;

  modport src (output valid, index, data, input ready);
  modport snk (input valid, index, data, output ready);
endinterface

// ----- sv/hea_ctrl.sv -----
module hea_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hea_pkg::sts_t sts_i,
  output hea_pkg::cmd_t cmd_o
);

  hea_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hea_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      hea_pkg::ST_IDLE: begin
        if (sts_i.tick) begin
          state_d = hea_pkg::ST_MAP;
        end
      end
      hea_pkg::ST_MAP: begin
        if (!sts_i.updated) begin
          state_d = hea_pkg::ST_IDLE;
        end else if (sts_i.need_div) begin
          state_d = hea_pkg::ST_ADIV;
        end else begin
          state_d = hea_pkg::ST_COMB;
        end
      end
      hea_pkg::ST_ADIV: begin
        if (sts_i.div_done) begin
          state_d = hea_pkg::ST_COMB;
        end
      end
      hea_pkg::ST_COMB: begin
        state_d = sts_i.vel_en ? hea_pkg::ST_DIFF : hea_pkg::ST_FIN;
      end
      hea_pkg::ST_DIFF:   state_d = hea_pkg::ST_VMUL;
      hea_pkg::ST_VMUL:   state_d = hea_pkg::ST_VDIV;
      hea_pkg::ST_VDIV: begin
        if (sts_i.div_done) begin
          state_d = hea_pkg::ST_VSAT;
        end
      end
      hea_pkg::ST_VSAT:   state_d = hea_pkg::ST_FMUL1;
      hea_pkg::ST_FMUL1:  state_d = hea_pkg::ST_FMUL2;
      hea_pkg::ST_FMUL2:  state_d = hea_pkg::ST_FSCALE;
      hea_pkg::ST_FSCALE: state_d = hea_pkg::ST_FIN;
      hea_pkg::ST_FIN: begin
        if (!sts_i.out_busy) begin
          state_d = hea_pkg::ST_IDLE;
        end
      end
      default: state_d = hea_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      hea_pkg::ST_IDLE:   cmd_o.accept = 1'b1;
      hea_pkg::ST_MAP:    cmd_o.map = 1'b1;
      hea_pkg::ST_ADIV:   cmd_o.div_step = !sts_i.div_done;
      hea_pkg::ST_COMB:   cmd_o.comb = 1'b1;
      hea_pkg::ST_DIFF:   cmd_o.diff = 1'b1;
      hea_pkg::ST_VMUL:   cmd_o.vmul = 1'b1;
      hea_pkg::ST_VDIV:   cmd_o.div_step = !sts_i.div_done;
      hea_pkg::ST_VSAT:   cmd_o.vsat = 1'b1;
      hea_pkg::ST_FMUL1:  cmd_o.fmul1 = 1'b1;
      hea_pkg::ST_FMUL2:  cmd_o.fmul2 = 1'b1;
      hea_pkg::ST_FSCALE: cmd_o.fscale = 1'b1;
      hea_pkg::ST_FIN:    cmd_o.fin = !sts_i.out_busy;
      default:            cmd_o = '0;
    endcase
  end

endmodule

// ----- sv/hea_dp.sv -----
module hea_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  hea_in_if.snk         in_i,
  hea_out_if.src        out_o,
  hea_cfg_if.snk        cfg_i,
  input  hea_pkg::cmd_t cmd_i,
  output hea_pkg::sts_t sts_o
);

  logic [15:0] zero_q, full_q, pmin_q, pmax_q, alpha_q;
  logic [31:0] tmo_q;
  logic [23:0] tpc_q;

  logic [31:0] rise_time_q, rise_time_d;
  logic        rise_seen_q, rise_seen_d;
  logic [15:0] pw_q, pw_d;
  logic [31:0] pulse_time_q, pulse_time_d;
  logic        good_q, good_d;
  logic [31:0] pwm_err_q, pwm_err_d;
  logic [31:0] ext_q, ext_d;
  logic [31:0] quad_err_q, quad_err_d;
  logic signed [47:0] quad_ang_q, quad_ang_d;
  logic [24:0] pwm_ang_q, pwm_ang_d;
  logic [24:0] off_ang_q, off_ang_d;
  logic        off_set_q, off_set_d;
  logic signed [47:0] last_ang_q, last_ang_d;
  logic signed [31:0] speed_q, speed_d;
  logic [31:0] last_upd_q, last_upd_d;
  logic        ever_q, ever_d;

  logic [31:0] now_q, now_d;
  logic [31:0] cnt_tot_q, cnt_tot_d;
  logic        ok_q, ok_d;
  logic        use_div_q, use_div_d;
  logic signed [47:0] comb_q, comb_d;
  logic [48:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic [33:0] rem_q, rem_d;
  logic [63:0] dvd_q, dvd_d;
  logic [33:0] dvs_q, dvs_d;
  logic [6:0]  step_q, step_d;
  logic signed [31:0] inst_q, inst_d;
  logic signed [49:0] acc_q, acc_d;

  logic               out_valid_q, out_valid_d;
  logic signed [47:0] out_ang_q, out_ang_d;
  logic signed [31:0] out_vel_q, out_vel_d;
  logic               out_ok_q, out_ok_d;
  logic [31:0]        out_err_q, out_err_d;

  logic        acc_in;
  logic [31:0] width;
  logic        map_go;
  logic [34:0] r2;
  logic        ge;
  logic signed [56:0] qprod;
  logic [24:0] pang;
  logic [24:0] off_eff;
  logic        latch;
  logic signed [56:0] csum;
  logic signed [49:0] d0, d1;
  logic [31:0] dt;
  logic [63:0] qc;
  logic signed [49:0] ftmp, fsh;
  logic [32:0] etot;

  assign acc_in    = cmd_i.accept && in_i.valid;
  assign in_i.ready = cmd_i.accept;
  assign cfg_i.ready = 1'b1;

  assign map_go = good_q && (pw_q != 16'd0);
  assign dt     = now_q - last_upd_q;

  assign sts_o.tick     = in_i.valid && (in_i.req_type == hea_pkg::REQ_UPDATE);
  assign sts_o.updated  = map_go || ok_q;
  assign sts_o.need_div = map_go && (pw_q > zero_q) && (pw_q < full_q);
  assign sts_o.div_done = (step_q == 7'd0);
  assign sts_o.vel_en   = (dt != 32'd0) && ever_q;
  assign sts_o.out_busy = out_valid_q && !out_o.ready;

  assign out_o.valid       = out_valid_q;
  assign out_o.angle       = out_ang_q;
  assign out_o.velocity    = out_vel_q;
  assign out_o.pwm_ok      = out_ok_q;
  assign out_o.data_valid  = 1'b1;
  assign out_o.error_total = out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q  <= hea_pkg::RST_PWM_ZERO;
      full_q  <= hea_pkg::RST_PWM_FULL;
      pmin_q  <= hea_pkg::RST_PULSE_MIN;
      pmax_q  <= hea_pkg::RST_PULSE_MAX;
      tmo_q   <= hea_pkg::RST_PWM_TMO;
      tpc_q   <= hea_pkg::RST_TPC;
      alpha_q <= hea_pkg::RST_ALPHA;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        hea_pkg::CFG_PWM_ZERO:   zero_q  <= cfg_i.data[15:0];
        hea_pkg::CFG_PWM_FULL:   full_q  <= cfg_i.data[15:0];
        hea_pkg::CFG_PULSE_MIN:  pmin_q  <= cfg_i.data[15:0];
        hea_pkg::CFG_PULSE_MAX:  pmax_q  <= cfg_i.data[15:0];
        hea_pkg::CFG_PWM_TMO:    tmo_q   <= cfg_i.data;
        hea_pkg::CFG_TURN_PER_C: tpc_q   <= cfg_i.data[23:0];
        hea_pkg::CFG_ALPHA:      alpha_q <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rise_time_d  = rise_time_q;
    rise_seen_d  = rise_seen_q;
    pw_d         = pw_q;
    pulse_time_d = pulse_time_q;
    good_d       = good_q;
    pwm_err_d    = pwm_err_q;
    ext_d        = ext_q;
    quad_err_d   = quad_err_q;
    quad_ang_d   = quad_ang_q;
    pwm_ang_d    = pwm_ang_q;
    off_ang_d    = off_ang_q;
    off_set_d    = off_set_q;
    last_ang_d   = last_ang_q;
    speed_d      = speed_q;
    last_upd_d   = last_upd_q;
    ever_d       = ever_q;
    now_d        = now_q;
    cnt_tot_d    = cnt_tot_q;
    ok_d         = ok_q;
    use_div_d    = use_div_q;
    comb_d       = comb_q;
    mag_d        = mag_q;
    neg_d        = neg_q;
    rem_d        = rem_q;
    dvd_d        = dvd_q;
    dvs_d        = dvs_q;
    step_d       = step_q;
    inst_d       = inst_q;
    acc_d        = acc_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_ang_d    = out_ang_q;
    out_vel_d    = out_vel_q;
    out_ok_d     = out_ok_q;
    out_err_d    = out_err_q;

    width   = in_i.time_us - rise_time_q;
    r2      = {rem_q, dvd_q[63]};
    ge      = (r2 >= {1'b0, dvs_q});
    qprod   = 57'($signed(cnt_tot_q)) * 57'($signed({1'b0, tpc_q}));
    pang    = use_div_q ? {1'b0, dvd_q[23:0]} : pwm_ang_q;
    latch   = !off_set_q && good_q;
    off_eff = latch ? pang : off_ang_q;
    csum    = 57'(quad_ang_q) + 57'($signed({1'b0, off_eff}));
    d0      = 50'(comb_q) - 50'(last_ang_q);
    d1      = d0;
    if (d0 > hea_pkg::HALF_TURN) begin
      d1 = d0 - hea_pkg::ONE_TURN;
    end else if (d0 < -hea_pkg::HALF_TURN) begin
      d1 = d0 + hea_pkg::ONE_TURN;
    end
    qc      = (dvd_q > hea_pkg::VEL_Q_CAP) ? hea_pkg::VEL_Q_CAP : dvd_q;
    ftmp    = acc_q + (acc_q[49] ? 50'sd65535 : 50'sd0);
    fsh     = ftmp >>> 16;
    etot    = {1'b0, pwm_err_q} + {1'b0, quad_err_q};

    if (acc_in) begin
      case (in_i.req_type)
        hea_pkg::REQ_EDGE: begin
          if (in_i.pin_level) begin
            rise_time_d = in_i.time_us;
            rise_seen_d = 1'b1;
          end else if (rise_seen_q) begin
            if ((width >= {16'd0, pmin_q}) && (width <= {16'd0, pmax_q})) begin
              pw_d         = width[15:0];
              pulse_time_d = in_i.time_us;
              good_d       = 1'b1;
            end else begin
              pwm_err_d = hea_pkg::inc_sat(pwm_err_q);
            end
          end
        end
        hea_pkg::REQ_LIMIT: begin
          ext_d = ext_q + (in_i.limit_high ? hea_pkg::LIMIT_HIGH_ADD : 32'd0)
                        + (in_i.limit_low ? hea_pkg::LIMIT_LOW_ADD : 32'd0);
        end
        hea_pkg::REQ_UPDATE: begin
          now_d     = in_i.time_us;
          ok_d      = in_i.count_ok;
          cnt_tot_d = ext_q + 32'($signed(in_i.count_now));
          if (!in_i.count_ok) begin
            quad_err_d = hea_pkg::inc_sat(quad_err_q);
          end
          if (good_q && ((in_i.time_us - pulse_time_q) > tmo_q)) begin
            good_d = 1'b0;
          end
        end
        hea_pkg::REQ_CLEAR: begin
          pwm_err_d  = 32'd0;
          quad_err_d = 32'd0;
        end
        default: ;
      endcase
    end

    if (cmd_i.map) begin
      use_div_d = sts_o.need_div;
      if (map_go) begin
        if (pw_q <= zero_q) begin
          pwm_ang_d = 25'd0;
        end else if (pw_q >= full_q) begin
          pwm_ang_d = hea_pkg::ONE_TURN_ANG;
        end else begin
          rem_d  = 34'(pw_q - zero_q);
          dvd_d  = 64'd0;
          dvs_d  = 34'(full_q - zero_q);
          step_d = hea_pkg::ANG_STEPS;
        end
      end
      if (ok_q) begin
        quad_ang_d = hea_pkg::sat48(qprod);
      end
    end

    if (cmd_i.div_step) begin
      rem_d  = ge ? 34'(r2 - {1'b0, dvs_q}) : r2[33:0];
      dvd_d  = {dvd_q[62:0], ge};
      step_d = step_q - 7'd1;
    end

    if (cmd_i.comb) begin
      pwm_ang_d = pang;
      if (latch) begin
        off_ang_d = pang;
        off_set_d = 1'b1;
      end
      comb_d = good_q ? hea_pkg::sat48(csum) : quad_ang_q;
    end

    if (cmd_i.diff) begin
      neg_d = d1[49];
      mag_d = d1[49] ? 49'(-d1) : d1[48:0];
    end

    if (cmd_i.vmul) begin
      dvd_d  = 64'(mag_q) * hea_pkg::VEL_NUM;
      rem_d  = 34'd0;
      dvs_d  = {dt, 2'b00};
      step_d = hea_pkg::VEL_STEPS;
    end

    if (cmd_i.vsat) begin
      if (neg_q) begin
        inst_d = -$signed(qc[31:0]);
      end else begin
        inst_d = qc[31] ? 32'sh7FFF_FFFF : $signed(qc[31:0]);
      end
    end

    if (cmd_i.fmul1) begin
      acc_d = 50'($signed({1'b0, alpha_q})) * 50'(inst_q);
    end

    if (cmd_i.fmul2) begin
      acc_d = acc_q + 50'($signed({1'b0, 17'(hea_pkg::ALPHA_ONE - {1'b0, alpha_q})}))
                      * 50'(speed_q);
    end

    if (cmd_i.fscale) begin
      if (!fsh[49] && (|fsh[48:31])) begin
        speed_d = 32'sh7FFF_FFFF;
      end else if (fsh[49] && !(&fsh[48:31])) begin
        speed_d = 32'sh8000_0000;
      end else begin
        speed_d = fsh[31:0];
      end
    end

    if (cmd_i.fin) begin
      last_ang_d  = comb_q;
      last_upd_d  = now_q;
      ever_d      = 1'b1;
      out_valid_d = 1'b1;
      out_ang_d   = comb_q;
      out_vel_d   = speed_q;
      out_ok_d    = good_q;
      out_err_d   = etot[32] ? 32'hFFFF_FFFF : etot[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_time_q  <= '0;
      rise_seen_q  <= 1'b0;
      pw_q         <= '0;
      pulse_time_q <= '0;
      good_q       <= 1'b0;
      pwm_err_q    <= '0;
      ext_q        <= '0;
      quad_err_q   <= '0;
      quad_ang_q   <= '0;
      pwm_ang_q    <= '0;
      off_ang_q    <= '0;
      off_set_q    <= 1'b0;
      last_ang_q   <= '0;
      speed_q      <= '0;
      last_upd_q   <= '0;
      ever_q       <= 1'b0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      rise_time_q  <= rise_time_d;
      rise_seen_q  <= rise_seen_d;
      pw_q         <= pw_d;
      pulse_time_q <= pulse_time_d;
      good_q       <= good_d;
      pwm_err_q    <= pwm_err_d;
      ext_q        <= ext_d;
      quad_err_q   <= quad_err_d;
      quad_ang_q   <= quad_ang_d;
      pwm_ang_q    <= pwm_ang_d;
      off_ang_q    <= off_ang_d;
      off_set_q    <= off_set_d;
      last_ang_q   <= last_ang_d;
      speed_q      <= speed_d;
      last_upd_q   <= last_upd_d;
      ever_q       <= ever_d;
      step_q       <= step_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    cnt_tot_q <= cnt_tot_d;
    ok_q      <= ok_d;
    use_div_q <= use_div_d;
    comb_q    <= comb_d;
    mag_q     <= mag_d;
    neg_q     <= neg_d;
    rem_q     <= rem_d;
    dvd_q     <= dvd_d;
    dvs_q     <= dvs_d;
    inst_q    <= inst_d;
    acc_q     <= acc_d;
    out_ang_q <= out_ang_d;
    out_vel_q <= out_vel_d;
    out_ok_q  <= out_ok_d;
    out_err_q <= out_err_d;
  end

endmodule

// ----- sv/hybrid_encoder_angle_velocity_core.sv -----
// Fuses a PWM absolute angle sensor with an extended quadrature count into a
// 48-bit angle in 2^-24 turns and an IIR-filtered velocity in 2^-16 turns per
// second. Pin edges, limit events and clear requests leave the block idle, so
// the next item can be taken straight after them. An update tick keeps the
// block busy; when it yields a word, one shared restoring divider produces one
// quotient bit per cycle where needed, 24 bits for the PWM angle mapping and 64
// bits for the velocity, followed by saturation, two filter products and a scale.
// A finished word waits in an output register while further items are taken.
module hybrid_encoder_angle_velocity_core (
  input logic clk_i,
  input logic rst_ni,
  hea_in_if.snk  in_i,
  hea_out_if.src out_o,
  hea_cfg_if.snk cfg_i
);

  hea_pkg::cmd_t cmd;
  hea_pkg::sts_t sts;

  hea_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  hea_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

`ifndef SYNTHESIS
  a_tick_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.req_type == hea_pkg::REQ_UPDATE)) |=> !in_i.ready)
    else $error("update tick did not occupy the block");

  a_simple_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.req_type != hea_pkg::REQ_UPDATE)) |=> in_i.ready)
    else $error("single-cycle request stalled the input");

  a_word_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.data_valid)
    else $error("word delivered without data_valid");
`endif

endmodule

// ----- dv/tb_hybrid_encoder_angle_velocity_core.sv -----
module tb_hybrid_encoder_angle_velocity_core;

  typedef struct packed {
    logic signed [47:0] angle;
    logic signed [31:0] velocity;
    logic               pwm_ok;
    logic               data_valid;
    logic [31:0]        error_total;
  } fusion_word_t;

  logic clk_i;
  logic rst_ni;

  hea_in_if  in_i ();
  hea_out_if out_o ();
  hea_cfg_if cfg_i ();

  hybrid_encoder_angle_velocity_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i.snk),
    .out_o (out_o.src),
    .cfg_i (cfg_i.snk)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Model configuration.
  logic [15:0] m_zero, m_full, m_pmin, m_pmax, m_alpha;
  logic [31:0] m_tmo;
  logic [23:0] m_tpc;

  // Model state.
  logic [31:0] m_rise_time, m_pulse_time, m_pwm_err, m_cnt_ext, m_quad_err;
  logic [31:0] m_pulse_w, m_last_upd;
  logic        m_rise_seen, m_pwm_good, m_off_set, m_ever;
  longint      m_quad_ang, m_pwm_ang, m_off_ang, m_last_ang, m_speed;

  fusion_word_t expected_words[$];

  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          recv_hold;
  logic [31:0] now_us;

  function automatic longint clamp48(longint v);
    if (v > 64'sd140737488355327) return 64'sd140737488355327;
    if (v < -64'sd140737488355328) return -64'sd140737488355328;
    return v;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [31:0] bump(logic [31:0] v);
    return (&v) ? v : v + 32'd1;
  endfunction

  task automatic reset_model();
    m_zero = hea_pkg::RST_PWM_ZERO; m_full = hea_pkg::RST_PWM_FULL;
    m_pmin = hea_pkg::RST_PULSE_MIN; m_pmax = hea_pkg::RST_PULSE_MAX;
    m_tmo = hea_pkg::RST_PWM_TMO; m_tpc = hea_pkg::RST_TPC; m_alpha = hea_pkg::RST_ALPHA;
    m_rise_time = '0; m_pulse_time = '0; m_pwm_err = '0; m_cnt_ext = '0; m_quad_err = '0;
    m_pulse_w = '0; m_last_upd = '0;
    m_rise_seen = 1'b0; m_pwm_good = 1'b0; m_off_set = 1'b0; m_ever = 1'b0;
    m_quad_ang = 0; m_pwm_ang = 0; m_off_ang = 0; m_last_ang = 0; m_speed = 0;
  endtask

  task automatic predict_fusion(logic [1:0] req, logic [31:0] t, logic pin, logic lh,
                                logic ll, logic signed [15:0] cnt, logic cok);
    logic [31:0]  w, dt, tot32;
    logic [63:0]  mag, q, tot64;
    longint       combined, diff, inst, acc;
    bit           updated;
    fusion_word_t wd;
    updated = 1'b0;
    case (req)
      hea_pkg::REQ_EDGE: begin
        if (pin) begin
          m_rise_time = t;
          m_rise_seen = 1'b1;
        end else if (m_rise_seen) begin
          w = t - m_rise_time;
          if (w >= {16'd0, m_pmin} && w <= {16'd0, m_pmax}) begin
            m_pulse_w = w;
            m_pulse_time = t;
            m_pwm_good = 1'b1;
          end else begin
            m_pwm_err = bump(m_pwm_err);
          end
        end
      end
      hea_pkg::REQ_LIMIT: begin
        if (lh) m_cnt_ext = m_cnt_ext + hea_pkg::LIMIT_HIGH_ADD;
        if (ll) m_cnt_ext = m_cnt_ext + hea_pkg::LIMIT_LOW_ADD;
      end
      hea_pkg::REQ_CLEAR: begin
        m_pwm_err = '0;
        m_quad_err = '0;
      end
      default: begin
        if (m_pwm_good && (t - m_pulse_time) > m_tmo) m_pwm_good = 1'b0;
        if (m_pwm_good && m_pulse_w != 0) begin
          if (m_pulse_w <= {16'd0, m_zero}) m_pwm_ang = 0;
          else if (m_pulse_w >= {16'd0, m_full}) m_pwm_ang = 64'sd16777216;
          else m_pwm_ang = longint'((64'(m_pulse_w - m_zero) << 24) / 64'(m_full - m_zero));
          updated = 1'b1;
        end
        if (cok) begin
          tot32 = m_cnt_ext + {{16{cnt[15]}}, cnt};
          m_quad_ang = clamp48(longint'(signed'(tot32)) * longint'({40'd0, m_tpc}));
          updated = 1'b1;
        end else begin
          m_quad_err = bump(m_quad_err);
        end
        if (updated) begin
          if (!m_off_set && m_pwm_good) begin
            m_off_ang = m_pwm_ang;
            m_off_set = 1'b1;
          end
          combined = (m_pwm_good && m_off_set) ? clamp48(m_quad_ang + m_off_ang)
                                               : m_quad_ang;
          dt = t - m_last_upd;
          if (dt != 0 && m_ever) begin
            diff = combined - m_last_ang;
            if (diff > 64'sd8388608) diff -= 64'sd16777216;
            if (diff < -64'sd8388608) diff += 64'sd16777216;
            mag = (diff < 0) ? 64'(-diff) : 64'(diff);
            q = (mag * 64'd15625) / (64'(dt) * 64'd4);
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            inst = (diff < 0) ? -longint'(q) : longint'(q);
            inst = clamp32(inst);
            acc = longint'({48'd0, m_alpha}) * inst
                + (64'sd65536 - longint'({48'd0, m_alpha})) * m_speed;
            m_speed = clamp32(acc / 64'sd65536);
          end
          m_last_ang = combined;
          m_last_upd = t;
          m_ever = 1'b1;
          tot64 = 64'(m_pwm_err) + 64'(m_quad_err);
          wd.angle = combined[47:0];
          wd.velocity = m_speed[31:0];
          wd.pwm_ok = m_pwm_good;
          wd.data_valid = 1'b1;
          wd.error_total = (tot64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tot64[31:0];
          expected_words.push_back(wd);
        end
      end
    endcase
  endtask

  task automatic send_item(logic [1:0] req, logic [31:0] t, logic pin, logic lh, logic ll,
                           logic signed [15:0] cnt, logic cok);
    while ($urandom_range(99) < send_idle_pct) begin
      in_i.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_i.valid <= 1'b1;
    in_i.req_type <= req;
    in_i.time_us <= t;
    in_i.pin_level <= pin;
    in_i.limit_high <= lh;
    in_i.limit_low <= ll;
    in_i.count_now <= cnt;
    in_i.count_ok <= cok;
    @(posedge clk_i);
    while (!in_i.ready) @(posedge clk_i);
    predict_fusion(req, t, pin, lh, ll, cnt, cok);
  endtask

  task automatic drain();
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [hea_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_i.valid <= 1'b1;
    cfg_i.index <= idx;
    cfg_i.data <= val;
    @(posedge clk_i);
    while (!cfg_i.ready) @(posedge clk_i);
    cfg_i.valid <= 1'b0;
    case (idx)
      hea_pkg::CFG_PWM_ZERO:   m_zero = val[15:0];
      hea_pkg::CFG_PWM_FULL:   m_full = val[15:0];
      hea_pkg::CFG_PULSE_MIN:  m_pmin = val[15:0];
      hea_pkg::CFG_PULSE_MAX:  m_pmax = val[15:0];
      hea_pkg::CFG_PWM_TMO:    m_tmo = val;
      hea_pkg::CFG_TURN_PER_C: m_tpc = val[23:0];
      hea_pkg::CFG_ALPHA:      m_alpha = val[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_pulse(logic [31:0] w);
    send_item(hea_pkg::REQ_EDGE, now_us, 1'b1, 1'b0, 1'b0, 16'sd0, 1'b0);
    now_us += w;
    send_item(hea_pkg::REQ_EDGE, now_us, 1'b0, 1'b0, 1'b0, 16'sd0, 1'b0);
  endtask

  task automatic test_directed();
    send_item(hea_pkg::REQ_EDGE, 32'd10, 1'b0, 1'b0, 1'b0, 16'sd0, 1'b0);
    send_item(hea_pkg::REQ_UPDATE, 32'd20, 1'b0, 1'b0, 1'b0, 16'sd0, 1'b0);
    send_item(hea_pkg::REQ_UPDATE, 32'd20, 1'b0, 1'b0, 1'b0, 16'sd100, 1'b1);
    send_item(hea_pkg::REQ_UPDATE, 32'd20, 1'b0, 1'b0, 1'b0, 16'sd200, 1'b1);
    now_us = 1000;
    send_pulse(32'd1500);
    send_item(hea_pkg::REQ_UPDATE, now_us + 5, 1'b0, 1'b0, 1'b0, 16'sd32767, 1'b1);
    send_pulse(32'd499);
    send_pulse(32'd2501);
    send_pulse(32'd500);
    send_item(hea_pkg::REQ_UPDATE, now_us + 7, 1'b0, 1'b0, 1'b0, 16'sh8000, 1'b1);
    send_pulse(32'd2500);
    send_item(hea_pkg::REQ_UPDATE, now_us + 9, 1'b1, 1'b1, 1'b1, -16'sd1, 1'b0);
    send_item(hea_pkg::REQ_LIMIT, now_us, 1'b0, 1'b1, 1'b0, 16'sd0, 1'b0);
    send_item(hea_pkg::REQ_LIMIT, now_us, 1'b0, 1'b0, 1'b1, 16'sd0, 1'b0);
    send_item(hea_pkg::REQ_LIMIT, now_us, 1'b0, 1'b1, 1'b1, 16'sd0, 1'b0);
    send_item(hea_pkg::REQ_UPDATE, now_us + 200000, 1'b0, 1'b0, 1'b0, 16'sd5, 1'b1);
    send_item(hea_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, -16'sd1, 1'b1);
    send_item(hea_pkg::REQ_UPDATE, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 16'sd7, 1'b1);
    send_item(hea_pkg::REQ_UPDATE, 32'd3, 1'b0, 1'b0, 1'b0, -16'sd7, 1'b1);
    in_i.valid <= 1'b0;
    drain();
  endtask

  task automatic random_items(int n);
    int unsigned k;
    logic [31:0] w;
    repeat (n) begin
      k = $urandom_range(99);
      if (k < 30) begin
        w = ($urandom_range(9) == 0) ? $urandom : {16'd0, m_pmin} +
            $urandom_range(32'(m_pmax >= m_pmin ? m_pmax - m_pmin : 0) + 2);
        send_pulse(w);
      end else if (k < 75) begin
        now_us += ($urandom_range(15) == 0) ? $urandom : $urandom_range(3000);
        send_item(hea_pkg::REQ_UPDATE, now_us, 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom),
                  $urandom_range(7) != 0);
      end else if (k < 88) begin
        send_item(hea_pkg::REQ_LIMIT, $urandom, 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom),
                  1'($urandom_range(1)));
      end else if (k < 92) begin
        send_item(hea_pkg::REQ_CLEAR, $urandom, 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom),
                  1'($urandom_range(1)));
      end else begin
        send_item(hea_pkg::REQ_EDGE, $urandom, 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom),
                  1'($urandom_range(1)));
      end
    end
    in_i.valid <= 1'b0;
  endtask

  task automatic test_default_cfg();
    random_items(250);
    drain();
  endtask

  task automatic test_extreme_cfg();
    write_reg(hea_pkg::CFG_PWM_ZERO, 32'd0);
    write_reg(hea_pkg::CFG_PWM_FULL, 32'd65535);
    write_reg(hea_pkg::CFG_PULSE_MIN, 32'd0);
    write_reg(hea_pkg::CFG_PULSE_MAX, 32'd65535);
    write_reg(hea_pkg::CFG_PWM_TMO, 32'hFFFF_FFFF);
    write_reg(hea_pkg::CFG_TURN_PER_C, 32'd8388608);
    write_reg(hea_pkg::CFG_ALPHA, 32'd65535);
    random_items(200);
    drain();
    write_reg(hea_pkg::CFG_PWM_ZERO, 32'd65535);
    write_reg(hea_pkg::CFG_PWM_FULL, 32'd1);
    write_reg(hea_pkg::CFG_PULSE_MIN, 32'd65535);
    write_reg(hea_pkg::CFG_PULSE_MAX, 32'd0);
    write_reg(hea_pkg::CFG_PWM_TMO, 32'd1);
    write_reg(hea_pkg::CFG_TURN_PER_C, 32'd1);
    write_reg(hea_pkg::CFG_ALPHA, 32'd0);
    random_items(150);
    drain();
  endtask

  task automatic test_mid_cfg_pressure();
    write_reg(hea_pkg::CFG_PWM_ZERO, 32'd900);
    write_reg(hea_pkg::CFG_PWM_FULL, 32'd2100);
    write_reg(hea_pkg::CFG_PULSE_MIN, 32'd800);
    write_reg(hea_pkg::CFG_PULSE_MAX, 32'd2200);
    write_reg(hea_pkg::CFG_PWM_TMO, 32'd5000);
    write_reg(hea_pkg::CFG_TURN_PER_C, 32'd12345);
    write_reg(hea_pkg::CFG_ALPHA, 32'd30000);
    recv_hold = 1'b1;
    fork
      begin
        repeat (1500) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      random_items(120);
    join
    drain();
    random_items(200);
    drain();
  endtask

  always @(posedge clk_i) begin
    if (out_o.valid && out_o.ready) begin
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, actual %h", $time, out_o.angle);
      end else begin
        fusion_word_t e;
        e = expected_words.pop_front();
        if (out_o.angle !== e.angle)
          begin errors++; $display("%0t: angle exp %0d act %0d", $time, e.angle,
                                   out_o.angle); end
        if (out_o.velocity !== e.velocity)
          begin errors++; $display("%0t: velocity exp %0d act %0d", $time, e.velocity,
                                   out_o.velocity); end
        if (out_o.pwm_ok !== e.pwm_ok)
          begin errors++; $display("%0t: pwm_ok exp %b act %b", $time, e.pwm_ok,
                                   out_o.pwm_ok); end
        if (out_o.data_valid !== e.data_valid)
          begin errors++; $display("%0t: data_valid exp %b act %b", $time, e.data_valid,
                                   out_o.data_valid); end
        if (out_o.error_total !== e.error_total)
          begin errors++; $display("%0t: error_total exp %0d act %0d", $time,
                                   e.error_total, out_o.error_total); end
      end
    end
    out_o.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_i.valid && in_i.ready) || (out_o.valid && out_o.ready) ||
        (cfg_i.valid && cfg_i.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    recv_hold = 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 50;
    now_us = '0;
    in_i.valid = 1'b0; in_i.req_type = hea_pkg::REQ_EDGE; in_i.time_us = '0;
    in_i.pin_level = 1'b0; in_i.limit_high = 1'b0; in_i.limit_low = 1'b0;
    in_i.count_now = '0; in_i.count_ok = 1'b0;
    out_o.ready = 1'b0;
    cfg_i.valid = 1'b0; cfg_i.index = hea_pkg::CFG_PWM_ZERO; cfg_i.data = '0;
    reset_model();
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_default_cfg();
    send_idle_pct = 50;
    recv_idle_pct = 36;
    test_extreme_cfg();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_mid_cfg_pressure();
    drain();
    if (errors == 0 && expected_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/hea_pkg.sv
sv/hea_if.sv
sv/hea_ctrl.sv
sv/hea_dp.sv
sv/hybrid_encoder_angle_velocity_core.sv
dv/tb_hybrid_encoder_angle_velocity_core.sv
